// File: hw/rtl/umeq_pkg.sv
// ----------------------------------------------------------------------------
// umeq_pkg
// Shared types and constants for the USB-MIDI event queue: opcodes, code
// index and status bytes, controller state and the command bundle.
// ----------------------------------------------------------------------------
package umeq_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_CTRL_CHG = 2'd2,
        OP_DRAIN    = 2'd3
    } t_opcode;

    localparam logic [7:0] CIN_NOTE_ON  = 8'h09;
    localparam logic [7:0] CIN_NOTE_OFF = 8'h08;
    localparam logic [7:0] CIN_CTRL_CHG = 8'h0B;
    localparam logic [7:0] ST_NOTE_ON   = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
    localparam logic [7:0] ST_CTRL_CHG  = 8'hB0;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_RESULT = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // Builds one event packet: code index, status with channel, two data bytes.
    function automatic logic [31:0] build_packet(
        input t_opcode    op,
        input logic [3:0] channel,
        input logic [6:0] key,
        input logic [6:0] amount
    );
        logic [7:0] cin;
        logic [7:0] status;
        case (op)
            OP_NOTE_ON: begin
                cin    = CIN_NOTE_ON;
                status = ST_NOTE_ON;
            end
            OP_NOTE_OFF: begin
                cin    = CIN_NOTE_OFF;
                status = ST_NOTE_OFF;
            end
            default: begin
                cin    = CIN_CTRL_CHG;
                status = ST_CTRL_CHG;
            end
        endcase
        return {cin, status | {4'd0, channel}, 1'b0, key, 1'b0, amount};
    endfunction

endpackage

// File: hw/rtl/umeq_ctrl.sv
// ----------------------------------------------------------------------------
// umeq_ctrl
// Sequencer: takes one item, runs the ring update, then holds the result
// until the consumer takes it.
// ----------------------------------------------------------------------------
module umeq_ctrl
    import umeq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // A taken item always gets its ring update on the next cycle.
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("load not followed by exec");

    // The ring update is followed by a presented result.
    a_exec_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid)
        else $error("exec not followed by result");

    // No new item is taken while a result is on the output.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out_valid && !o_in_stall))
        else $error("input open while result pending");
`endif

endmodule

// File: hw/rtl/umeq_datapath.sv
// ----------------------------------------------------------------------------
// umeq_datapath
// Item registers, ring pointers, slot memory and result registers.
// ----------------------------------------------------------------------------
module umeq_datapath
    import umeq_pkg::*;
#(
    parameter int RING_EVENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_key,
    input  logic [6:0]  i_amount,
    input  logic        i_endpoint_ready,
    output logic        o_accepted,
    output logic        o_dropped,
    output logic [1:0]  o_sent_count,
    output logic [31:0] o_first_packet,
    output logic [31:0] o_second_packet
);

    localparam int PTR_W = (RING_EVENTS > 1) ? $clog2(RING_EVENTS) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_EVENTS - 1);

    t_opcode          r_opcode;
    logic [3:0]       r_channel;
    logic [6:0]       r_key;
    logic [6:0]       r_amount;
    logic             r_ready;

    logic [PTR_W-1:0] r_read_slot;
    logic [PTR_W-1:0] r_write_slot;
    logic [31:0]      r_slots [RING_EVENTS];
    logic [31:0]      r_rd0;
    logic [31:0]      r_rd1;

    logic             r_accepted;
    logic             r_dropped;
    logic [1:0]       r_sent_count;

    logic [PTR_W-1:0] nxt_w;
    logic [PTR_W-1:0] nxt_r;
    logic [PTR_W-1:0] nxt_r2;
    logic             is_event;
    logic             full;
    logic             empty;
    logic             pair;
    logic             do_write;
    logic             do_send;

    always_comb begin
        nxt_w    = (r_write_slot == LAST) ? '0 : r_write_slot + 1'b1;
        nxt_r    = (r_read_slot == LAST) ? '0 : r_read_slot + 1'b1;
        nxt_r2   = (nxt_r == LAST) ? '0 : nxt_r + 1'b1;
        is_event = (r_opcode != OP_DRAIN);
        full     = (nxt_w == r_read_slot);
        empty    = (r_read_slot == r_write_slot);
        // A second packet goes out only if queued and the pair does not wrap.
        pair     = (nxt_r != r_write_slot) && (nxt_r != '0);
        do_write = is_event && !full;
        do_send  = !is_event && !empty && r_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode  <= t_opcode'(i_opcode);
            r_channel <= i_channel;
            r_key     <= i_key;
            r_amount  <= i_amount;
            r_ready   <= i_endpoint_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_slot  <= '0;
            r_write_slot <= '0;
            r_accepted   <= 1'b0;
            r_dropped    <= 1'b0;
            r_sent_count <= 2'd0;
        end else if (i_cmd.exec) begin
            r_accepted   <= do_write;
            r_dropped    <= is_event && full;
            r_sent_count <= !do_send ? 2'd0 : (pair ? 2'd2 : 2'd1);
            if (do_write) begin
                r_write_slot <= nxt_w;
            end
            if (do_send) begin
                r_read_slot <= pair ? nxt_r2 : nxt_r;
            end
        end
    end

    // Slot memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && do_write) begin
            r_slots[r_write_slot] <= build_packet(r_opcode, r_channel, r_key, r_amount);
        end
        if (i_cmd.exec) begin
            r_rd0 <= r_slots[r_read_slot];
            r_rd1 <= r_slots[nxt_r];
        end
    end

    assign o_accepted      = r_accepted;
    assign o_dropped       = r_dropped;
    assign o_sent_count    = r_sent_count;
    assign o_first_packet  = (r_sent_count != 2'd0) ? r_rd0 : 32'd0;
    assign o_second_packet = (r_sent_count == 2'd2) ? r_rd1 : 32'd0;

`ifndef NO_ASSERTIONS
    // Store and drop are exclusive outcomes of one event.
    a_acc_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_accepted && r_dropped))
        else $error("accepted and dropped both set");

    // A drain result never reports an event outcome.
    a_send_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sent_count != 2'd0) |-> (!r_accepted && !r_dropped))
        else $error("send and event outcome together");

    // Ring pointers never leave the ring, also for depths that are not powers of two.
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_read_slot <= LAST) && (r_write_slot <= LAST))
        else $error("ring pointer out of range");

    // Pointers only move during the ring update cycle.
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.exec) |-> ($stable(r_read_slot) && $stable(r_write_slot)))
        else $error("ring pointer moved outside exec");
`endif

endmodule

// File: hw/rtl/usb_midi_event_queue_top.sv
// A transfer taken on the input is loaded, runs the ring update and is then
// presented in the result state. The sequencer runs a single item through
// load, ring update and result hold and takes no new item until its result
// is taken. The slot memory read is registered, which sets the ring update cycle.
// Reset (i_rst_n low, synchronous) empties the ring by clearing both pointers;
// slot contents are left as they are and are only sent after being written.
// ----------------------------------------------------------------------------
// usb_midi_event_queue_top
// USB-MIDI event packet queue. Note on, note off and control change items
// become 4-byte event packets stored in a ring with one slot kept free; a full
// ring drops the event. A drain to a ready endpoint sends up to two packets.
// ----------------------------------------------------------------------------
module usb_midi_event_queue_top
    import umeq_pkg::*;
#(
    parameter int RING_EVENTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_channel,
    input  logic [6:0]  i_key,
    input  logic [6:0]  i_amount,
    input  logic        i_endpoint_ready,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output logic        o_dropped,
    output logic [1:0]  o_sent_count,
    output logic [31:0] o_first_packet,
    output logic [31:0] o_second_packet
);

    // Command bundle from the sequencer to the datapath.
    t_cmd cmd;

    // The sequencer decides when an item is loaded, processed and presented.
    umeq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // The datapath holds the ring and builds the packets. Result registers
    // stay constant while the result waits, so a stalled transfer holds.
    umeq_datapath #(
        .RING_EVENTS (RING_EVENTS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_channel        (i_channel),
        .i_key            (i_key),
        .i_amount         (i_amount),
        .i_endpoint_ready (i_endpoint_ready),
        .o_accepted       (o_accepted),
        .o_dropped        (o_dropped),
        .o_sent_count     (o_sent_count),
        .o_first_packet   (o_first_packet),
        .o_second_packet  (o_second_packet)
    );

endmodule

// File: tb/tb_usb_midi_event_queue_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_midi_event_queue_top
// Self-checking bench for the USB-MIDI event queue. A tracker class keeps its
// own copy of the packet ring and predicts the result of every accepted item.
// Each returned result is compared field by field with the oldest prediction.
// A directed opening covers the opcodes, field extremes, an empty and busy
// drain, paired drains and a full ring. Random segments follow, some biased
// toward filling the ring and some toward draining it.
// ----------------------------------------------------------------------------
module tb_usb_midi_event_queue_top
    import umeq_pkg::*;
();

    localparam int RING_SLOTS  = 16;
    localparam int RANDOM_ITEMS = 1850;
    // The limit leaves ample room for the slowest correct run: the per-item handshake,
    // the longest sender gap, the longest receiver stall and the long hold-offs.
    localparam int CYCLE_LIMIT = 600000;
    // Results sampled before the first long receiver hold-off, then between them.
    localparam int HOLD_FIRST  = 300;
    localparam int HOLD_EVERY  = 700;
    localparam int HOLD_CYCLES = 200;

    // One result item of the block, in the order of its output ports.
    typedef struct packed {
        logic        accepted;
        logic        dropped;
        logic [1:0]  sent_count;
        logic [31:0] first_packet;
        logic [31:0] second_packet;
    } t_outcome;

    // Tracks the packet ring as the block should see it. Every accepted input
    // transfer gets its outcome computed right away and queued; every result
    // transfer is checked against the head of that queue.
    class midi_queue_tracker;
        logic [31:0] slots [RING_SLOTS];
        int unsigned rd_pos;
        int unsigned wr_pos;
        t_outcome    awaited [$];
        int unsigned mismatches;
        int unsigned reported;

        function t_outcome predict_outcome(t_opcode op, logic [3:0] channel,
                                           logic [6:0] key, logic [6:0] amount,
                                           logic ready);
            t_outcome    res;
            logic [7:0]  cin;
            logic [7:0]  status;
            int unsigned nxt;
            res = '0;
            if (op != OP_DRAIN) begin
                case (op)
                    OP_NOTE_ON: begin
                        cin    = CIN_NOTE_ON;
                        status = ST_NOTE_ON;
                    end
                    OP_NOTE_OFF: begin
                        cin    = CIN_NOTE_OFF;
                        status = ST_NOTE_OFF;
                    end
                    default: begin
                        cin    = CIN_CTRL_CHG;
                        status = ST_CTRL_CHG;
                    end
                endcase
                nxt = (wr_pos + 1) % RING_SLOTS;
                // One slot always stays free, so a full ring drops the event.
                if (nxt == rd_pos) begin
                    res.dropped = 1'b1;
                end else begin
                    slots[wr_pos] = {cin, status | {4'd0, channel},
                                     1'b0, key, 1'b0, amount};
                    wr_pos = nxt;
                    res.accepted = 1'b1;
                end
            end else if (rd_pos != wr_pos && ready) begin
                nxt = (rd_pos + 1) % RING_SLOTS;
                res.first_packet = slots[rd_pos];
                res.sent_count   = 2'd1;
                // A second packet goes along only when queued and not wrapping.
                if (nxt != wr_pos && nxt != 0) begin
                    res.second_packet = slots[nxt];
                    res.sent_count    = 2'd2;
                    nxt = (nxt + 1) % RING_SLOTS;
                end
                rd_pos = nxt;
            end
            return res;
        endfunction

        function void take_item(t_opcode op, logic [3:0] channel, logic [6:0] key,
                                logic [6:0] amount, logic ready);
            awaited.push_back(predict_outcome(op, channel, key, amount, ready));
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (reported < 40) begin
                    reported++;
                    $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                end
            end
        endfunction

        function void match_outcome(t_outcome got);
            t_outcome want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (reported < 40) begin
                    reported++;
                    $error("result transfer with no outstanding item");
                end
                return;
            end
            want = awaited.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(got.accepted));
            check_field("dropped", 32'(want.dropped), 32'(got.dropped));
            check_field("sent_count", 32'(want.sent_count), 32'(got.sent_count));
            check_field("first_packet", want.first_packet, got.first_packet);
            check_field("second_packet", want.second_packet, got.second_packet);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_opcode;
    logic [3:0]  i_channel;
    logic [6:0]  i_key;
    logic [6:0]  i_amount;
    logic        i_endpoint_ready;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_accepted;
    logic        o_dropped;
    logic [1:0]  o_sent_count;
    logic [31:0] o_first_packet;
    logic [31:0] o_second_packet;

    midi_queue_tracker tracker = new();
    // Percentage of input transfers preceded by an idle gap; set per segment.
    int unsigned gap_pct = 0;
    int          cycle_count = 0;

    usb_midi_event_queue_top #(
        .RING_EVENTS(RING_SLOTS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_channel       (i_channel),
        .i_key           (i_key),
        .i_amount        (i_amount),
        .i_endpoint_ready(i_endpoint_ready),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_dropped       (o_dropped),
        .o_sent_count    (o_sent_count),
        .o_first_packet  (o_first_packet),
        .o_second_packet (o_second_packet)
    );

    // 4 ns clock period.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Gaps come at the set percentage; most are short, and now and then a long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) >= gap_pct) begin
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 30);
        end
        return $urandom_range(1, 3);
    endfunction

    // Data bytes lean toward their extremes so both ends get hit often.
    function automatic logic [6:0] pick_data();
        case ($urandom_range(0, 7))
            0: return 7'd0;
            1: return 7'd127;
            default: return 7'($urandom_range(0, 127));
        endcase
    endfunction

    // Offers one item on the input channel and holds it until the transfer.
    // Inputs change on the falling edge; the stall is sampled on the rising edge.
    // Valid stays high from one item into the next when there is no gap.
    task automatic send_item(t_opcode op, logic [3:0] channel, logic [6:0] key,
                             logic [6:0] amount, logic ready);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_opcode         <= op;
        i_channel        <= channel;
        i_key            <= key;
        i_amount         <= amount;
        i_endpoint_ready <= ready;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                break;
            end
        end
        tracker.take_item(op, channel, key, amount, ready);
    endtask

    // Result side. Stall runs start at random with a per-phase probability,
    // including phases with no stall at all. Every so often the receiver holds
    // off for a long stretch so the block backs up and stalls its input while
    // the sender keeps offering items.
    initial begin
        int unsigned hold_left;
        int unsigned run_left;
        int unsigned phase_left;
        int unsigned stall_pct;
        int unsigned results_seen;
        logic        stall;
        hold_left    = 0;
        run_left     = 0;
        phase_left   = 0;
        stall_pct    = 0;
        results_seen = 0;
        i_out_stall  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                stall = 1'b1;
                hold_left--;
            end else if (run_left > 0) begin
                stall = 1'b1;
                run_left--;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(50, 300);
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 15;
                        default: stall_pct = 40;
                    endcase
                end
                phase_left--;
                if ($urandom_range(0, 99) < stall_pct) begin
                    stall    = 1'b1;
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(0, 2);
                end else begin
                    stall = 1'b0;
                end
            end
            i_out_stall <= stall;
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                tracker.match_outcome({o_accepted, o_dropped, o_sent_count,
                                       o_first_packet, o_second_packet});
                results_seen++;
                if (results_seen % HOLD_EVERY == HOLD_FIRST) begin
                    hold_left = HOLD_CYCLES;
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned sent_items;
        int unsigned seg_len;
        int unsigned event_pct;
        int unsigned ready_pct;
        t_opcode     op;
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_opcode         = OP_NOTE_ON;
        i_channel        = 4'd0;
        i_key            = 7'd0;
        i_amount         = 7'd0;
        i_endpoint_ready = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Draining an empty ring sends nothing, whether or not the endpoint is ready.
        send_item(OP_DRAIN, 4'd0, 7'd0, 7'd0, 1'b1);
        send_item(OP_DRAIN, 4'd15, 7'd127, 7'd127, 1'b0);
        // Each event kind with the field extremes.
        send_item(OP_NOTE_ON, 4'd0, 7'd0, 7'd0, 1'b0);
        send_item(OP_NOTE_OFF, 4'd15, 7'd127, 7'd127, 1'b1);
        send_item(OP_CTRL_CHG, 4'd5, 7'h55, 7'h2A, 1'b0);
        // A busy endpoint leaves the queued packets in place.
        send_item(OP_DRAIN, 4'd0, 7'd0, 7'd0, 1'b0);
        // A pair goes out, then the lone remaining packet.
        send_item(OP_DRAIN, 4'd0, 7'd0, 7'd0, 1'b1);
        send_item(OP_DRAIN, 4'd0, 7'd0, 7'd0, 1'b1);
        // Fill the ring until it is full; the last event is dropped.
        for (int n = 0; n < RING_SLOTS; n++) begin
            send_item(t_opcode'(n % 3), 4'(n), 7'(n * 8), 7'(127 - n * 8), 1'b1);
        end
        // A drain from the full ring sends the two oldest packets as a pair.
        send_item(OP_DRAIN, 4'd9, 7'd1, 7'd2, 1'b1);

        // Random segments, each with its own mix: fill-heavy, drain-heavy,
        // balanced, or balanced with a mostly busy endpoint.
        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            seg_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 25;
                default: gap_pct = 60;
            endcase
            ready_pct = 90;
            case ($urandom_range(0, 3))
                0: event_pct = 85;
                1: event_pct = 30;
                2: event_pct = 55;
                default: begin
                    event_pct = 60;
                    ready_pct = 30;
                end
            endcase
            for (int n = 0; n < seg_len; n++) begin
                if ($urandom_range(0, 99) < event_pct) begin
                    op = t_opcode'($urandom_range(0, 2));
                end else begin
                    op = OP_DRAIN;
                end
                send_item(op, 4'($urandom_range(0, 15)), pick_data(), pick_data(),
                          ($urandom_range(0, 99) < ready_pct));
                sent_items++;
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Let every outstanding result come back, then a few more cycles to
        // catch any stray result transfer.
        while (tracker.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: usb_midi_event_queue_top.f
hw/rtl/umeq_pkg.sv
hw/rtl/umeq_ctrl.sv
hw/rtl/umeq_datapath.sv
hw/rtl/usb_midi_event_queue_top.sv
tb/tb_usb_midi_event_queue_top.sv
